// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the deframer RTL.
// No dependencies; included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a property in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ----- rtl/sfd_pkg.sv -----
// Types, constants and lookup functions of the serial frame deframer.
// No dependencies; used by sfd_parser, sfd_out_reg and the top level.
`default_nettype none

package sfd_pkg;

    localparam int DATA_CAPACITY = 128;

    localparam logic [15:0] HEADER_LEN = 16'd5;
    localparam logic [15:0] CMD_LEN    = 16'd2;
    localparam logic [15:0] TAIL_LEN   = 16'd2;

    localparam logic [7:0] START_BYTE_RST = 8'hA5;

    localparam int KNOWN_IDS = 17;

    localparam logic [15:0] KNOWN_ID [KNOWN_IDS] = '{
        16'h0001, 16'h0002, 16'h0003, 16'h0004,
        16'h0101, 16'h0102, 16'h0104, 16'h0105,
        16'h0201, 16'h0202, 16'h0203, 16'h0204, 16'h0205,
        16'h0206, 16'h0207, 16'h0208, 16'h0209
    };

    localparam logic [15:0] RECORD_LEN [KNOWN_IDS] = '{
        16'd3,  16'd1,  16'd32, 16'd3,
        16'd4,  16'd4,  16'd2,  16'd1,
        16'd27, 16'd16, 16'd16, 16'd1, 16'd2,
        16'd1,  16'd7,  16'd6,  16'd4
    };

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_HEADER = 3'd1,
        MODE_CMD    = 3'd2,
        MODE_DATA   = 3'd3,
        MODE_TAIL   = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        ST_IGNORED     = 4'd0,
        ST_HEADER_BYTE = 4'd1,
        ST_HEADER_DONE = 4'd2,
        ST_CMD_BYTE    = 4'd3,
        ST_CMD_DONE    = 4'd4,
        ST_DATA_BYTE   = 4'd5,
        ST_DATA_DONE   = 4'd6,
        ST_TAIL_BYTE   = 4'd7,
        ST_TAIL_DONE   = 4'd8,
        ST_OVERFLOW    = 4'd9
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  byte_value;
        logic [15:0] offset;
        logic [15:0] data_length;
        logic [7:0]  seq_out;
        logic [7:0]  header_crc;
        logic [15:0] command_out;
        logic [4:0]  record_slot;
        logic        in_record;
        logic [15:0] frame_crc;
    } t_result;

    // Position 1..17 of an id in the known-id table, 0 when it is not listed.
    function automatic logic [4:0] f_find_slot(input logic [15:0] id);
        logic [4:0] slot;
        slot = '0;
        for (int i = KNOWN_IDS - 1; i >= 0; i--) begin
            if (KNOWN_ID[i] == id) begin
                slot = 5'(i + 1);
            end
        end
        return slot;
    endfunction

    function automatic logic [15:0] f_record_len(input logic [4:0] slot);
        logic [4:0] idx;
        idx = slot - 5'd1;
        if (slot == 5'd0) begin
            return 16'd0;
        end
        return RECORD_LEN[idx];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sfd_in_reg.sv -----
// Input holding register of the deframer: one received byte and its valid flag.
// Depends on nothing but the port list.
`default_nettype none

module sfd_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data,
    input  wire logic       i_take,
    output logic            o_valid,
    output logic [7:0]      o_data
);

    logic       r_valid;
    logic [7:0] r_data;

    // The slot frees up in the same cycle as the parser takes its byte.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sfd_parser.sv -----
// Segment state machine of the deframer: decodes one byte per step and
// builds its status result. Depends on sfd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sfd_parser #(
    parameter int DATA_CAPACITY = sfd_pkg::DATA_CAPACITY
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output sfd_pkg::t_result o_result
);

    sfd_pkg::t_mode r_mode;
    sfd_pkg::t_mode n_mode;
    logic [15:0]    r_pos;
    logic [15:0]    n_pos;
    logic [15:0]    r_len;
    logic [15:0]    n_len;
    logic [15:0]    r_frame_len;
    logic [15:0]    n_frame_len;
    logic [7:0]     r_seq;
    logic [7:0]     n_seq;
    logic [7:0]     r_hdr_crc;
    logic [7:0]     n_hdr_crc;
    logic [15:0]    r_cmd_id;
    logic [15:0]    n_cmd_id;
    logic [15:0]    r_tail_crc;
    logic [15:0]    n_tail_crc;
    logic [4:0]     r_slot;
    logic [4:0]     n_slot;
    logic [7:0]     r_start;
    logic [7:0]     r_seg [4];

    logic [15:0]       pos_d;
    logic              active;
    logic              seg_done;
    logic              seg_wr;
    logic [15:0]       off;
    sfd_pkg::t_status  status;

    always_comb begin
        n_mode = r_mode;
        n_len  = r_len;
        // A segment switches on the byte after its last byte.
        case (r_mode)
            sfd_pkg::MODE_HEADER: begin
                if (r_pos == r_len) begin
                    n_mode = sfd_pkg::MODE_CMD;
                    n_len  = sfd_pkg::CMD_LEN;
                end
            end
            sfd_pkg::MODE_CMD: begin
                if (r_pos == r_len) begin
                    n_mode = sfd_pkg::MODE_DATA;
                    n_len  = r_frame_len;
                end
            end
            sfd_pkg::MODE_DATA: begin
                if (r_pos == r_len) begin
                    n_mode = sfd_pkg::MODE_TAIL;
                    n_len  = sfd_pkg::TAIL_LEN;
                end
            end
            sfd_pkg::MODE_TAIL: begin
                if (r_pos == r_len && i_byte == r_start) begin
                    n_mode = sfd_pkg::MODE_HEADER;
                    n_len  = sfd_pkg::HEADER_LEN;
                end
            end
            default: begin
                if (i_byte == r_start) begin
                    n_mode = sfd_pkg::MODE_HEADER;
                    n_len  = sfd_pkg::HEADER_LEN;
                end else begin
                    n_mode = sfd_pkg::MODE_IDLE;
                end
            end
        endcase

        pos_d    = (n_mode != r_mode) ? 16'd0 : r_pos;
        active   = (n_mode != sfd_pkg::MODE_IDLE) && (pos_d < n_len);
        off      = active ? pos_d : 16'd0;
        n_pos    = active ? pos_d + 16'd1 : pos_d;
        seg_done = active && (n_pos == n_len);
        seg_wr   = active && (n_mode != sfd_pkg::MODE_DATA) && (pos_d < 16'd4);

        n_frame_len = r_frame_len;
        n_seq       = r_seq;
        n_hdr_crc   = r_hdr_crc;
        n_cmd_id    = r_cmd_id;
        n_tail_crc  = r_tail_crc;
        n_slot      = r_slot;
        status      = sfd_pkg::ST_IGNORED;

        if (active) begin
            case (n_mode)
                sfd_pkg::MODE_HEADER: begin
                    status = sfd_pkg::ST_HEADER_BYTE;
                    if (seg_done) begin
                        // The last header byte is the CRC8 and arrives now.
                        n_frame_len = {r_seg[2], r_seg[1]};
                        n_seq       = r_seg[3];
                        n_hdr_crc   = i_byte;
                        status      = sfd_pkg::ST_HEADER_DONE;
                    end
                end
                sfd_pkg::MODE_CMD: begin
                    status = sfd_pkg::ST_CMD_BYTE;
                    if (seg_done) begin
                        n_cmd_id = {i_byte, r_seg[0]};
                        n_slot   = sfd_pkg::f_find_slot({i_byte, r_seg[0]});
                        status   = sfd_pkg::ST_CMD_DONE;
                    end
                end
                sfd_pkg::MODE_DATA: begin
                    if ({1'b0, pos_d} >= 17'(DATA_CAPACITY)) begin
                        status = sfd_pkg::ST_OVERFLOW;
                    end else if (seg_done) begin
                        status = sfd_pkg::ST_DATA_DONE;
                    end else begin
                        status = sfd_pkg::ST_DATA_BYTE;
                    end
                end
                default: begin
                    status = sfd_pkg::ST_TAIL_BYTE;
                    if (seg_done) begin
                        n_tail_crc = {r_seg[0], i_byte};
                        status     = sfd_pkg::ST_TAIL_DONE;
                    end
                end
            endcase
        end

        o_result.status      = status;
        o_result.byte_value  = i_byte;
        o_result.offset      = off;
        o_result.data_length = n_frame_len;
        o_result.seq_out     = n_seq;
        o_result.header_crc  = n_hdr_crc;
        o_result.command_out = n_cmd_id;
        o_result.record_slot = n_slot;
        o_result.frame_crc   = n_tail_crc;
        o_result.in_record   = (status == sfd_pkg::ST_DATA_BYTE
                                || status == sfd_pkg::ST_DATA_DONE)
                               && (n_slot != 5'd0)
                               && (off < sfd_pkg::f_record_len(n_slot));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= sfd_pkg::MODE_IDLE;
            r_pos       <= '0;
            r_len       <= '0;
            r_frame_len <= '0;
            r_seq       <= '0;
            r_hdr_crc   <= '0;
            r_cmd_id    <= '0;
            r_tail_crc  <= '0;
            r_slot      <= '0;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_frame_len <= n_frame_len;
            r_seq       <= n_seq;
            r_hdr_crc   <= n_hdr_crc;
            r_cmd_id    <= n_cmd_id;
            r_tail_crc  <= n_tail_crc;
            r_slot      <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= sfd_pkg::START_BYTE_RST;
        end else if (i_cfg_wr_en) begin
            r_start <= i_cfg_wr_data;
        end
    end

    // Segment bytes are only read after being written in the same segment.
    always_ff @(posedge i_clk) begin
        if (i_step && seg_wr) begin
            r_seg[pos_d[1:0]] <= i_byte;
        end
    end

    `ASSERT_HOLDS(a_pos_within_len, i_clk, i_rst_n, r_pos <= r_len,
        "segment position ran past segment length")
    `ASSERT_HOLDS(a_idle_cleared, i_clk, i_rst_n,
        (r_mode != sfd_pkg::MODE_IDLE) || (r_pos == 16'd0 && r_len == 16'd0),
        "idle mode with a live segment counter")
    `ASSERT_HOLDS(a_record_on_data, i_clk, i_rst_n,
        !o_result.in_record || status == sfd_pkg::ST_DATA_BYTE
        || status == sfd_pkg::ST_DATA_DONE,
        "record mark on a byte that is not data")

endmodule

`default_nettype wire

// ----- rtl/sfd_out_reg.sv -----
// Result register of the deframer, holding one status result until taken.
// Depends on sfd_pkg.
`default_nettype none

module sfd_out_reg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  sfd_pkg::t_result i_result,
    output logic             o_can_load,
    output logic             o_valid,
    input  wire logic        i_ready,
    output sfd_pkg::t_result o_result
);

    logic             r_valid;
    sfd_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/serial_frame_deframer.sv -----
// Top level of the serial frame deframer: input register, segment parser and
// result register. Depends on sfd_pkg, sfd_in_reg, sfd_parser, sfd_out_reg.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: rx_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready    tuser: status; tdata: result
//  cfg       in   i_cfg_wr_en                    i_cfg_wr_data: start_byte
//
// One byte is taken per cycle while m_axis does not stall; each byte gives one
// result, passing through the input register, the parser and the result register.
// Reset is synchronous and active low; it leaves the parser idle and the
// start byte at 0xA5.
// A stall on m_axis holds the result register; s_axis_tready falls as soon as
// the input register holds a byte, so at most one further byte is taken.
`default_nettype none
`include "assert_macros.svh"

module serial_frame_deframer #(
    parameter int DATA_CAPACITY = sfd_pkg::DATA_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [3:0]       m_axis_tuser,   // [3:0] status
    // [7:0] byte_value, [23:8] offset, [39:24] data_length, [47:40] seq_out,
    // [55:48] header_crc, [71:56] command_out, [76:72] record_slot,
    // [77] in_record, [93:78] frame_crc, [95:94] zero
    output logic [95:0]      m_axis_tdata
);

    logic             in_valid;
    logic [7:0]       in_byte;
    logic             out_can_load;
    logic             step;
    sfd_pkg::t_result parsed;
    sfd_pkg::t_result result;

    // The parser advances exactly when a byte moves into the result register.
    assign step = in_valid && out_can_load;

    sfd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_take  (step),
        .o_valid (in_valid),
        .o_data  (in_byte)
    );

    sfd_parser #(
        .DATA_CAPACITY (DATA_CAPACITY)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_byte        (in_byte),
        .o_result      (parsed)
    );

    sfd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (parsed),
        .o_can_load (out_can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (result)
    );

    assign m_axis_tuser = result.status;
    assign m_axis_tdata = {2'b00, result.frame_crc, result.in_record, result.record_slot,
                           result.command_out, result.header_crc, result.seq_out,
                           result.data_length, result.offset, result.byte_value};

    `ASSERT_HOLDS(a_stall_means_full, i_clk, i_rst_n,
        s_axis_tready || (in_valid && m_axis_tvalid),
        "input side stalled while a register is free")
    `ASSERT_NEXT(a_step_fills_output, i_clk, i_rst_n, step, m_axis_tvalid,
        "parsed byte did not reach the result register")

endmodule

`default_nettype wire

// ----- dv/tb_serial_frame_deframer.sv -----
// Self-checking testbench of serial_frame_deframer: feeds received bytes on the
// stream input and checks every status transaction against a predictor of the parser.
// Depends on sfd_pkg and the serial_frame_deframer RTL.
module tb_serial_frame_deframer;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_ITEMS = 560;
    localparam int CFG_EVERY    = 200;
    localparam int LONG_KEEP    = 160;

    // Known command ids and the record length that belongs to each of them.
    localparam logic [15:0] CMD_IDS [sfd_pkg::KNOWN_IDS] = '{
        16'h0001, 16'h0002, 16'h0003, 16'h0004,
        16'h0101, 16'h0102, 16'h0104, 16'h0105,
        16'h0201, 16'h0202, 16'h0203, 16'h0204, 16'h0205,
        16'h0206, 16'h0207, 16'h0208, 16'h0209
    };
    localparam logic [15:0] CMD_RECORD_LEN [sfd_pkg::KNOWN_IDS] = '{
        16'd3,  16'd1,  16'd32, 16'd3,
        16'd4,  16'd4,  16'd2,  16'd1,
        16'd27, 16'd16, 16'd16, 16'd1, 16'd2,
        16'd1,  16'd7,  16'd6,  16'd4
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [3:0]  m_axis_tuser;   // [3:0] status
    // [7:0] byte_value, [23:8] offset, [39:24] data_length, [47:40] seq_out,
    // [55:48] header_crc, [71:56] command_out, [76:72] record_slot,
    // [77] in_record, [93:78] frame_crc, [95:94] zero
    logic [95:0] m_axis_tdata;

    // Predictor copy of the parser state and of the start byte register.
    sfd_pkg::t_mode fr_mode;
    logic [15:0]    fr_pos;
    logic [15:0]    fr_len;
    logic [7:0]     fr_bytes [5];
    logic [15:0]    fr_length;
    logic [7:0]     fr_seq;
    logic [7:0]     fr_hdr_crc;
    logic [15:0]    fr_cmd;
    logic [15:0]    fr_tail_crc;
    logic [7:0]     fr_start;

    sfd_pkg::t_result awaited_reports [$];
    bit               idling_on;
    int               fail_count;
    int               parsed_items;

    serial_frame_deframer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advances the predicted parser by one received byte and returns its status report.
    function automatic sfd_pkg::t_result deframe_byte(input logic [7:0] rx);
        sfd_pkg::t_mode   prior;
        logic [15:0]      off;
        logic [4:0]       slot;
        sfd_pkg::t_result r;
        prior = fr_mode;
        off   = '0;
        slot  = '0;
        r     = '0;
        r.status = sfd_pkg::ST_IGNORED;
        case (fr_mode)
            sfd_pkg::MODE_HEADER: begin
                if (fr_pos == fr_len) begin
                    fr_mode = sfd_pkg::MODE_CMD;
                    fr_len  = sfd_pkg::CMD_LEN;
                end
            end
            sfd_pkg::MODE_CMD: begin
                if (fr_pos == fr_len) begin
                    fr_mode = sfd_pkg::MODE_DATA;
                    fr_len  = fr_length;
                end
            end
            sfd_pkg::MODE_DATA: begin
                if (fr_pos == fr_len) begin
                    fr_mode = sfd_pkg::MODE_TAIL;
                    fr_len  = sfd_pkg::TAIL_LEN;
                end
            end
            sfd_pkg::MODE_TAIL: begin
                if (fr_pos == fr_len && rx == fr_start) begin
                    fr_mode = sfd_pkg::MODE_HEADER;
                    fr_len  = sfd_pkg::HEADER_LEN;
                end
            end
            default: begin
                if (rx == fr_start) begin
                    fr_mode = sfd_pkg::MODE_HEADER;
                    fr_len  = sfd_pkg::HEADER_LEN;
                end else begin
                    fr_mode = sfd_pkg::MODE_IDLE;
                end
            end
        endcase
        if (fr_mode != prior) fr_pos = '0;

        if (fr_mode != sfd_pkg::MODE_IDLE && fr_pos < fr_len) begin
            off = fr_pos;
            if (fr_mode != sfd_pkg::MODE_DATA) fr_bytes[off[2:0]] = rx;
            fr_pos = fr_pos + 16'd1;
            case (fr_mode)
                sfd_pkg::MODE_HEADER: r.status = sfd_pkg::ST_HEADER_BYTE;
                sfd_pkg::MODE_CMD:    r.status = sfd_pkg::ST_CMD_BYTE;
                sfd_pkg::MODE_DATA: begin
                    if (off >= sfd_pkg::DATA_CAPACITY) r.status = sfd_pkg::ST_OVERFLOW;
                    else r.status = sfd_pkg::ST_DATA_BYTE;
                end
                default:              r.status = sfd_pkg::ST_TAIL_BYTE;
            endcase
            if (fr_pos == fr_len) begin
                case (fr_mode)
                    sfd_pkg::MODE_HEADER: begin
                        fr_length  = {fr_bytes[2], fr_bytes[1]};
                        fr_seq     = fr_bytes[3];
                        fr_hdr_crc = fr_bytes[4];
                        r.status   = sfd_pkg::ST_HEADER_DONE;
                    end
                    sfd_pkg::MODE_CMD: begin
                        fr_cmd   = {fr_bytes[1], fr_bytes[0]};
                        r.status = sfd_pkg::ST_CMD_DONE;
                    end
                    sfd_pkg::MODE_DATA: begin
                        // An overflowing last byte keeps its overflow status.
                        if (r.status == sfd_pkg::ST_DATA_BYTE) r.status = sfd_pkg::ST_DATA_DONE;
                    end
                    default: begin
                        fr_tail_crc = {fr_bytes[0], fr_bytes[1]};
                        r.status    = sfd_pkg::ST_TAIL_DONE;
                    end
                endcase
            end
        end

        for (int i = 0; i < sfd_pkg::KNOWN_IDS; i++) begin
            if (slot == 5'd0 && CMD_IDS[i] == fr_cmd) slot = 5'(i + 1);
        end
        r.byte_value  = rx;
        r.offset      = off;
        r.data_length = fr_length;
        r.seq_out     = fr_seq;
        r.header_crc  = fr_hdr_crc;
        r.command_out = fr_cmd;
        r.record_slot = slot;
        r.frame_crc   = fr_tail_crc;
        r.in_record   = 1'b0;
        if ((r.status == sfd_pkg::ST_DATA_BYTE || r.status == sfd_pkg::ST_DATA_DONE)
            && slot != 5'd0) begin
            if (off < CMD_RECORD_LEN[slot - 5'd1]) r.in_record = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [7:0] other_than_start();
        logic [7:0] v;
        do v = 8'($urandom); while (v == fr_start);
        return v;
    endfunction

    // Offers one byte, after a random gap while idling_on is set, and records its
    // predicted report once the transaction has taken place. The valid stays high for a following byte.
    task automatic send_rx_byte(input logic [7:0] rx);
        int               gap;
        sfd_pkg::t_result r;
        gap = idling_on ? $urandom_range(0, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        do @(posedge i_clk); while (!s_axis_tready);
        r = deframe_byte(rx);
        awaited_reports.push_back(r);
        if (r.status != sfd_pkg::ST_IGNORED) parsed_items++;
    endtask

    task automatic drain_results;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_byte(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        fr_start = value;
    endtask

    // Sends a frame with random sequence, CRC and payload. Only the first body_keep
    // bytes after the command are sent, so a small value cuts the frame short.
    task automatic send_frame(input logic [15:0] len, input logic [15:0] cmd,
                              input int body_keep);
        int body;
        send_rx_byte(fr_start);
        send_rx_byte(len[7:0]);
        send_rx_byte(len[15:8]);
        send_rx_byte(8'($urandom));
        send_rx_byte(8'($urandom));
        send_rx_byte(cmd[7:0]);
        send_rx_byte(cmd[15:8]);
        // An empty data segment swallows one byte before the tail starts.
        body = ((len == 16'd0) ? 1 : int'(len)) + int'(sfd_pkg::TAIL_LEN);
        for (int i = 0; i < body && i < body_keep; i++) send_rx_byte(8'($urandom));
    endtask

    // Fills a cut frame until its tail is complete; half of the filler bytes carry
    // the start value, which must not open a frame before then.
    task automatic resync_parser;
        while (!(fr_mode == sfd_pkg::MODE_IDLE
                 || (fr_mode == sfd_pkg::MODE_TAIL && fr_pos == fr_len))) begin
            send_rx_byte(($urandom_range(0, 1) != 0) ? fr_start : other_than_start());
        end
    endtask

    task automatic test_directed_frames;
        logic [7:0] stream [$];
        stream = '{
            8'h00, 8'hFF, 8'h5A,
            8'hA5, 8'h04, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h00,
            8'hFF, 8'h00, 8'h80, 8'h7F, 8'h12, 8'h34,
            8'h77,
            8'hA5, 8'h00, 8'h00, 8'h5A, 8'hC3, 8'h09, 8'h02,
            8'hEE, 8'hAB, 8'hCD
        };
        foreach (stream[i]) send_rx_byte(stream[i]);
        drain_results;
    endtask

    task automatic test_start_byte_config;
        logic [7:0] settings [4];
        settings = '{8'h00, 8'hFF, 8'($urandom), sfd_pkg::START_BYTE_RST};
        foreach (settings[i]) begin
            write_start_byte(settings[i]);
            send_rx_byte(other_than_start());
            send_rx_byte(other_than_start());
            send_frame(16'($urandom_range(0, 6)),
                       CMD_IDS[$urandom_range(0, sfd_pkg::KNOWN_IDS - 1)], 1 << 20);
            send_rx_byte(other_than_start());
            drain_results;
        end
    endtask

    task automatic test_random_traffic;
        int          first;
        int          next_cfg;
        int          pick;
        logic [15:0] len;
        logic [15:0] cmd;
        first    = parsed_items;
        next_cfg = CFG_EVERY;
        while (parsed_items - first < RANDOM_ITEMS) begin
            idling_on = ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 7) len = 16'($urandom_range(0, 12));
            else if (pick < 9) len = 16'($urandom_range(13, 40));
            else len = 16'($urandom_range(120, 140));
            if ($urandom_range(0, 3) != 0) begin
                cmd = CMD_IDS[$urandom_range(0, sfd_pkg::KNOWN_IDS - 1)];
            end else begin
                cmd = 16'($urandom);
            end
            if ($urandom_range(0, 7) == 0) begin
                send_frame(len, cmd, $urandom_range(0, 4));
                resync_parser;
            end else begin
                send_frame(len, cmd, 1 << 20);
            end
            repeat ($urandom_range(0, 3)) send_rx_byte(other_than_start());
            if (parsed_items - first >= next_cfg) begin
                drain_results;
                write_start_byte(8'($urandom));
                next_cfg += CFG_EVERY;
            end
        end
        idling_on = 1'b1;
        drain_results;
    endtask

    // The start of a frame of the largest length, sent without gaps, so that the
    // length field reaches its top value and the data runs well into overflow.
    task automatic test_longest_frame;
        resync_parser;
        idling_on = 1'b0;
        send_frame(16'hFFFF, 16'h0003, LONG_KEEP);
        idling_on = 1'b1;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    initial begin : result_checker
        sfd_pkg::t_result want;
        int               stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = idling_on ? $urandom_range(0, 9) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (awaited_reports.size() == 0) begin
                $error("unexpected status transaction: status %0d, byte 0x%0h",
                       m_axis_tuser, m_axis_tdata[7:0]);
                fail_count++;
            end else begin
                want = awaited_reports.pop_front();
                compare_field("status",      16'(want.status),  16'(m_axis_tuser));
                compare_field("byte_value",  16'(want.byte_value), 16'(m_axis_tdata[7:0]));
                compare_field("offset",      want.offset,       m_axis_tdata[23:8]);
                compare_field("data_length", want.data_length,  m_axis_tdata[39:24]);
                compare_field("seq_out",     16'(want.seq_out), 16'(m_axis_tdata[47:40]));
                compare_field("header_crc",  16'(want.header_crc), 16'(m_axis_tdata[55:48]));
                compare_field("command_out", want.command_out,  m_axis_tdata[71:56]);
                compare_field("record_slot", 16'(want.record_slot), 16'(m_axis_tdata[76:72]));
                compare_field("in_record",   16'(want.in_record), 16'(m_axis_tdata[77]));
                compare_field("frame_crc",   want.frame_crc,    m_axis_tdata[93:78]);
            end
        end
    end

    initial begin : cycle_watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("serial_frame_deframer regression: fail");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idling_on     = 1'b1;
        fail_count    = 0;
        parsed_items  = 0;
        fr_mode       = sfd_pkg::MODE_IDLE;
        fr_pos        = '0;
        fr_len        = '0;
        fr_length     = '0;
        fr_seq        = '0;
        fr_hdr_crc    = '0;
        fr_cmd        = '0;
        fr_tail_crc   = '0;
        fr_start      = sfd_pkg::START_BYTE_RST;
        foreach (fr_bytes[i]) fr_bytes[i] = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames;
        test_start_byte_config;
        test_random_traffic;
        test_longest_frame;

        drain_results;
        if (fail_count == 0) begin
            $display("serial_frame_deframer regression: pass");
        end else begin
            $display("serial_frame_deframer regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_in_reg.sv
rtl/sfd_parser.sv
rtl/sfd_out_reg.sv
rtl/serial_frame_deframer.sv
dv/tb_serial_frame_deframer.sv
